// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked at every clock edge out of reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at every clock edge out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mwc_pkg.sv =====
// ----------------------------------------------------------------------------
// mwc_pkg
// types and constants for the lag-2 multiply-with-carry generator
// ----------------------------------------------------------------------------
package mwc_pkg;

    // generator multiplier and default warm-up length after seeding
    localparam logic [15:0] MWC_MULT         = 16'd52563;
    localparam int          WARMUP_STEPS_DEF = 12;

    // request codes
    typedef enum logic {
        OP_SEED = 1'b0,
        OP_NEXT = 1'b1
    } t_opcode;

    // input item
    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] seed_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] random_word;
    } t_out_item;

endpackage

// ===== hdl/mwc_stream_if.sv =====
// ----------------------------------------------------------------------------
// mwc_stream_if
// valid/ready channel carrying one item of payload type T
// ----------------------------------------------------------------------------
interface mwc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    // producer side
    modport source (output valid, output data, input ready);
    // consumer side
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mwc_lag2_16bit_xxa_prng.sv =====
// ----------------------------------------------------------------------------
// mwc_lag2_16bit_xxa_prng
// lag-2 multiply-with-carry generator, 16-bit lags, xor/add output mixing
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries request items (opcode, seed_value); o_out carries result
//   items (random_word). Both are valid/ready channels, an item moves on an
//   edge with valid and ready high.
//   A next request runs two lag steps through the one 16x16 multiplier, one
//   step per cycle while o_out does not stall the last step, and returns one
//   32-bit word (first step in the upper half). The word shows on o_out the
//   cycle after the second step, and a new request is taken in that cycle.
//   A seed request loads the lags, sets the carry to one and runs
//   WARMUP_STEPS discarded steps and gives no result.
//   The sequencer handles one request at a time; i_in.ready is high while
//   it is idle, even if a result still waits in the output register.
//   If o_out is stalled when a next request reaches its last step, that
//   step waits until the output register frees up.
//   Reset (synchronous, active low) sets the lags to zero, the carry to one
//   and empties the output register; a next request may follow at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwc_lag2_16bit_xxa_prng #(
    parameter int WARMUP_STEPS = mwc_pkg::WARMUP_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mwc_stream_if.sink   i_in,
    mwc_stream_if.source o_out
);
    import mwc_pkg::*;

    localparam int CNT_MAX = (WARMUP_STEPS > 2) ? WARMUP_STEPS : 2;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_WARM = CNT_W'(WARMUP_STEPS);
    localparam logic [CNT_W-1:0] CNT_NEXT = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_STEP = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_is_next, n_is_next;
    logic [15:0]      r_lag_newest, n_lag_newest;
    logic [15:0]      r_lag_oldest, n_lag_oldest;
    logic [15:0]      r_carry, n_carry;
    logic [15:0]      r_hi, n_hi;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_word, n_out_word;

    logic [31:0] prod;
    logic [31:0] t_sum;
    logic [15:0] step_value;
    logic        in_take;
    logic        out_free;
    logic        last_step;
    logic        step_go;

    // shared step unit: one multiply, mix and carry add
    always_comb begin
        prod       = 32'(MWC_MULT) * 32'(r_lag_oldest);
        step_value = (r_lag_oldest ^ r_lag_newest) + (r_carry ^ prod[31:16]);
        t_sum      = prod + 32'(r_carry);
    end

    // handshake
    assign i_in.ready        = (r_state == S_IDLE);
    assign in_take           = i_in.valid && i_in.ready;
    assign out_free          = !r_out_valid || o_out.ready;
    assign last_step         = (r_cnt == CNT_ONE);
    assign step_go           = (r_state == S_STEP) && !(r_is_next && last_step && !out_free);
    assign o_out.valid       = r_out_valid;
    assign o_out.data.random_word = r_out_word;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_is_next    = r_is_next;
        n_lag_newest = r_lag_newest;
        n_lag_oldest = r_lag_oldest;
        n_carry      = r_carry;
        n_hi         = r_hi;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_word   = r_out_word;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_in.data.opcode == OP_SEED) begin
                        n_lag_newest = i_in.data.seed_value[15:0];
                        n_lag_oldest = i_in.data.seed_value[31:16];
                        n_carry      = 16'd1;
                        n_cnt        = CNT_WARM;
                        n_is_next    = 1'b0;
                        n_state      = (WARMUP_STEPS == 0) ? S_IDLE : S_STEP;
                    end else begin
                        n_cnt     = CNT_NEXT;
                        n_is_next = 1'b1;
                        n_state   = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (step_go) begin
                    n_lag_oldest = r_lag_newest;
                    n_lag_newest = t_sum[15:0];
                    n_carry      = t_sum[31:16];
                    n_hi         = step_value;
                    n_cnt        = r_cnt - CNT_ONE;
                    if (last_step) begin
                        n_state = S_IDLE;
                        if (r_is_next) begin
                            n_out_valid = 1'b1;
                            n_out_word  = {r_hi, step_value};
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_is_next    <= 1'b0;
            r_lag_newest <= 16'd0;
            r_lag_oldest <= 16'd0;
            r_carry      <= 16'd1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_is_next    <= n_is_next;
            r_lag_newest <= n_lag_newest;
            r_lag_oldest <= n_lag_oldest;
            r_carry      <= n_carry;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_out_word <= n_out_word;
    end

    // checks
    `ASSERT_NEXT(a_out_from_next, !r_out_valid, !r_out_valid || ($past(r_state == S_STEP) && $past(r_is_next)), "result without a next request")
    `ASSERT_IMPLIES(a_cnt_nonzero, r_state == S_STEP, r_cnt != '0, "step state with zero count")
    `ASSERT_NEXT(a_seed_load, in_take && i_in.data.opcode == OP_SEED, r_carry == 16'd1 || WARMUP_STEPS != 0, "seed did not set carry")
    `ASSERT_NEXT(a_no_drop, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out_word), "pending result lost")

endmodule
